// ===== design/awfca_pkg.sv =====
// ----------------------------------------------------------------------------
// awfca_pkg
// Shared types and constants for the channel block averager.
// ----------------------------------------------------------------------------
package awfca_pkg;

    localparam int CHAN_W     = 3;
    localparam int SMP_W      = 12;
    localparam int SUM_W      = 21;
    localparam int CNT_W      = 10;
    localparam int MASK_W     = 6;
    localparam int OHM_W      = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;
    localparam int PROD_W     = 2 * SMP_W;

    localparam logic [SUM_W-1:0] SUM_MAX    = {SUM_W{1'b1}};
    localparam logic [CNT_W-1:0] CNT_MAX    = {CNT_W{1'b1}};
    localparam logic [SMP_W-1:0] FULL_SCALE = 12'd4095;

    localparam logic [CFG_IDX_W-1:0] REG_FILTER_MASK = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT_LOW   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT_HIGH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_VREF_MV     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_OHM_OFFSET  = 3'd4;

    localparam logic [MASK_W-1:0] RST_FILTER_MASK = 6'd0;
    localparam logic [SMP_W-1:0]  RST_LIMIT_LOW   = 12'd700;
    localparam logic [SMP_W-1:0]  RST_LIMIT_HIGH  = 12'd3657;
    localparam logic [SMP_W-1:0]  RST_VREF_MV     = 12'd3359;
    localparam logic [OHM_W-1:0]  RST_OHM_OFFSET  = 8'd60;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int DIV_STEPS   = SUM_W;
    localparam int STEP_W      = $clog2(DIV_STEPS);

    typedef struct packed {
        logic [MASK_W-1:0] filter_mask;
        logic [SMP_W-1:0]  limit_low;
        logic [SMP_W-1:0]  limit_high;
        logic [SMP_W-1:0]  vref_mv;
        logic [OHM_W-1:0]  ohm_offset;
    } t_cfg;

    typedef struct packed {
        logic [CHAN_W-1:0] chan;
        logic [SUM_W-1:0]  sum;
        logic [CNT_W-1:0]  cnt;
    } t_job;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIV,
        BK_MUL,
        BK_SCALE
    } t_back_state;

endpackage

// ===== design/awfca_front.sv =====
// ----------------------------------------------------------------------------
// awfca_front
// Takes sample beats, applies the range filter and accumulates per channel;
// on a block end it hands the channel's sum and count to the job queue.
// ----------------------------------------------------------------------------
module awfca_front #(
    parameter int NUM_CHANNELS = 6
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  awfca_pkg::t_cfg               i_cfg,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [awfca_pkg::CHAN_W-1:0]  i_chan,
    input  logic [awfca_pkg::SMP_W-1:0]   i_sample,
    input  logic                          i_last,
    input  logic                          i_q_full,
    output logic                          o_push,
    output awfca_pkg::t_job               o_job
);

    localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    logic [awfca_pkg::SUM_W-1:0] r_sum [NUM_CHANNELS];
    logic [awfca_pkg::CNT_W-1:0] r_cnt [NUM_CHANNELS];

    logic [CH_W-1:0]             w_idx;
    logic                        w_chan_ok;
    logic                        w_filtered;
    logic                        w_in_range;
    logic [awfca_pkg::SUM_W:0]   w_sum_ext;
    logic                        w_add;
    logic [awfca_pkg::SUM_W-1:0] n_sum;
    logic [awfca_pkg::CNT_W-1:0] n_cnt;
    logic                        w_fire;

    assign o_ready    = !i_q_full;
    assign w_idx      = CH_W'(i_chan);
    assign w_chan_ok  = int'(i_chan) < NUM_CHANNELS;
    assign w_filtered = (int'(i_chan) < awfca_pkg::MASK_W) && i_cfg.filter_mask[i_chan];
    assign w_in_range = (i_sample > i_cfg.limit_low) && (i_sample < i_cfg.limit_high);
    assign w_sum_ext  = {1'b0, r_sum[w_idx]} + (awfca_pkg::SUM_W+1)'(i_sample);
    assign w_add      = (!w_filtered || w_in_range)
                      && (r_cnt[w_idx] != awfca_pkg::CNT_MAX)
                      && (w_sum_ext <= {1'b0, awfca_pkg::SUM_MAX});
    assign n_sum      = w_add ? w_sum_ext[awfca_pkg::SUM_W-1:0] : r_sum[w_idx];
    assign n_cnt      = w_add ? r_cnt[w_idx] + 1'b1 : r_cnt[w_idx];
    assign w_fire     = i_valid && o_ready && w_chan_ok;

    assign o_push     = w_fire && i_last;
    assign o_job.chan = i_chan;
    assign o_job.sum  = n_sum;
    assign o_job.cnt  = n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                r_sum[i] <= '0;
                r_cnt[i] <= '0;
            end
        end else if (w_fire) begin
            if (i_last) begin
                r_sum[w_idx] <= '0;
                r_cnt[w_idx] <= '0;
            end else begin
                r_sum[w_idx] <= n_sum;
                r_cnt[w_idx] <= n_cnt;
            end
        end
    end

endmodule

// ===== design/awfca_queue.sv =====
// ----------------------------------------------------------------------------
// awfca_queue
// Short job queue between the accumulating front and the dividing back.
// ----------------------------------------------------------------------------
module awfca_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  awfca_pkg::t_job  i_job,
    input  logic             i_pop,
    output awfca_pkg::t_job  o_job,
    output logic             o_full,
    output logic             o_empty
);

    awfca_pkg::t_job r_mem [awfca_pkg::QUEUE_DEPTH];

    logic [awfca_pkg::QPTR_W-1:0] r_wr_ptr;
    logic [awfca_pkg::QPTR_W-1:0] r_rd_ptr;
    logic [awfca_pkg::QPTR_W:0]   r_fill;

    assign o_full  = r_fill == (awfca_pkg::QPTR_W+1)'(awfca_pkg::QUEUE_DEPTH);
    assign o_empty = r_fill == '0;
    assign o_job   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_fill <= r_fill + 1'b1;
            end else if (i_pop && !i_push) begin
                r_fill <= r_fill - 1'b1;
            end
        end
    end

endmodule

// ===== design/awfca_back.sv =====
// ----------------------------------------------------------------------------
// awfca_back
// Divides a finished block's sum by its count one bit a cycle, keeps the
// channel averages, scales to millivolts and ohms and holds the result beat.
// ----------------------------------------------------------------------------
module awfca_back #(
    parameter int NUM_CHANNELS = 6
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  awfca_pkg::t_cfg               i_cfg,
    input  logic                          i_q_empty,
    input  awfca_pkg::t_job               i_job,
    output logic                          o_pop,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [awfca_pkg::CHAN_W-1:0]  o_chan,
    output logic [awfca_pkg::SMP_W-1:0]   o_average,
    output logic [awfca_pkg::SMP_W-1:0]   o_millivolts,
    output logic [awfca_pkg::SMP_W-1:0]   o_resistance,
    output logic                          o_fresh
);

    localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int SW   = awfca_pkg::SMP_W;
    localparam int PW   = awfca_pkg::PROD_W;

    awfca_pkg::t_back_state r_state;
    awfca_pkg::t_back_state n_state;

    logic [SW-1:0]                    r_avg [NUM_CHANNELS];
    logic [awfca_pkg::CHAN_W-1:0]     r_chan;
    logic                             r_fresh;
    logic [awfca_pkg::SUM_W-1:0]      r_dvd;
    logic [awfca_pkg::CNT_W-1:0]      r_div;
    logic [awfca_pkg::CNT_W-1:0]      r_rem;
    logic [awfca_pkg::STEP_W-1:0]     r_step;
    logic [SW-1:0]                    r_cur_avg;
    logic [PW-1:0]                    r_prod;
    logic                             r_out_valid;
    logic [awfca_pkg::CHAN_W-1:0]     r_out_chan;
    logic [SW-1:0]                    r_out_avg;
    logic [SW-1:0]                    r_out_mv;
    logic [SW-1:0]                    r_out_ohm;
    logic                             r_out_fresh;

    logic [awfca_pkg::CNT_W:0]        w_trial;
    logic                             w_ge;
    logic [awfca_pkg::CNT_W:0]        w_rem_sub;
    logic                             w_div_done;
    logic [awfca_pkg::SUM_W-1:0]      w_quo;
    logic [PW:0]                      w_q_sum;
    logic [SW:0]                      w_q0;
    logic [PW:0]                      w_q0_mul;
    logic [PW:0]                      w_r;
    logic [SW-1:0]                    w_mv;
    logic [SW:0]                      w_ohm;
    logic                             w_out_free;
    logic                             w_load_out;
    logic                             w_start;

    assign w_trial    = {r_rem, r_dvd[awfca_pkg::SUM_W-1]};
    assign w_ge       = w_trial >= {1'b0, r_div};
    assign w_rem_sub  = w_trial - {1'b0, r_div};
    assign w_div_done = r_step == awfca_pkg::STEP_W'(awfca_pkg::DIV_STEPS - 1);
    assign w_quo      = {r_dvd[awfca_pkg::SUM_W-2:0], w_ge};

    // divide by 4095: estimate from the 4096 split, then one correction
    assign w_q_sum  = (PW+1)'(r_prod) + (PW+1)'(r_prod >> SW);
    assign w_q0     = w_q_sum[PW:SW];
    assign w_q0_mul = ((PW+1)'(w_q0) << SW) - (PW+1)'(w_q0);
    assign w_r      = (PW+1)'(r_prod) - w_q0_mul;
    assign w_mv     = (w_r >= (PW+1)'(awfca_pkg::FULL_SCALE)) ? SW'(w_q0 + 1'b1) : SW'(w_q0);
    assign w_ohm    = (SW+1)'(w_mv >> 1) + (SW+1)'(i_cfg.ohm_offset);

    assign w_out_free = !r_out_valid || i_ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            awfca_pkg::BK_IDLE: begin
                if (!i_q_empty) begin
                    n_state = (i_job.cnt != '0) ? awfca_pkg::BK_DIV : awfca_pkg::BK_MUL;
                end
            end
            awfca_pkg::BK_DIV: begin
                if (w_div_done) begin
                    n_state = awfca_pkg::BK_MUL;
                end
            end
            awfca_pkg::BK_MUL: begin
                n_state = awfca_pkg::BK_SCALE;
            end
            awfca_pkg::BK_SCALE: begin
                if (w_out_free) begin
                    n_state = awfca_pkg::BK_IDLE;
                end
            end
            default: begin
                n_state = awfca_pkg::BK_IDLE;
            end
        endcase
    end

    always_comb begin
        w_start    = 1'b0;
        w_load_out = 1'b0;
        unique case (r_state)
            awfca_pkg::BK_IDLE:  w_start    = !i_q_empty;
            awfca_pkg::BK_SCALE: w_load_out = w_out_free;
            default: begin
                w_start    = 1'b0;
                w_load_out = 1'b0;
            end
        endcase
    end

    assign o_pop = w_start;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= awfca_pkg::BK_IDLE;
            r_out_valid <= 1'b0;
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                r_avg[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            if (r_state == awfca_pkg::BK_DIV && w_div_done) begin
                r_avg[CH_W'(r_chan)] <= w_quo[SW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_start) begin
            r_chan    <= i_job.chan;
            r_fresh   <= i_job.cnt != '0;
            r_dvd     <= i_job.sum;
            r_div     <= i_job.cnt;
            r_rem     <= '0;
            r_step    <= '0;
            r_cur_avg <= r_avg[CH_W'(i_job.chan)];
        end
        if (r_state == awfca_pkg::BK_DIV) begin
            r_dvd  <= w_quo;
            r_rem  <= w_ge ? w_rem_sub[awfca_pkg::CNT_W-1:0] : w_trial[awfca_pkg::CNT_W-1:0];
            r_step <= r_step + 1'b1;
            if (w_div_done) begin
                r_cur_avg <= w_quo[SW-1:0];
            end
        end
        if (r_state == awfca_pkg::BK_MUL) begin
            r_prod <= r_cur_avg * i_cfg.vref_mv;
        end
        if (w_load_out) begin
            r_out_chan  <= r_chan;
            r_out_avg   <= r_cur_avg;
            r_out_mv    <= w_mv;
            r_out_ohm   <= w_ohm[SW-1:0];
            r_out_fresh <= r_fresh;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_chan       = r_out_chan;
    assign o_average    = r_out_avg;
    assign o_millivolts = r_out_mv;
    assign o_resistance = r_out_ohm;
    assign o_fresh      = r_out_fresh;

endmodule

// ===== design/adc_window_filtered_channel_average_unit.sv =====
// ----------------------------------------------------------------------------
// adc_window_filtered_channel_average_unit
// Per-channel block averager for interleaved converter samples with an
// optional range filter and millivolt / ohm scaling.
// ----------------------------------------------------------------------------
// Input beats carry a channel and a sample; tlast marks that channel's last
// sample of a block. A beat with a channel at or above NUM_CHANNELS is taken
// and dropped. The front takes one beat per cycle and stalls only while the
// four-entry job queue is full.
// A block end queues the channel's sum and count; the back turns each job
// into one result beat. A block with accepted samples runs a bit-serial
// divide, then the multiply and scale states load the output register; a
// block with nothing accepted keeps the old average and skips the divide.
// The back handles one job at a time, bounded by the divider.
// The result beat sits in an output register; while the receiver stalls the
// back waits with its job and the queue keeps filling, then tready drops.
// Reset clears all sums, counts and averages and loads the register
// defaults. Configuration writes take effect at the next clock edge.
// ----------------------------------------------------------------------------
module adc_window_filtered_channel_average_unit #(
    parameter int NUM_CHANNELS = 6
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [awfca_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [awfca_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [15:0]                       s_axis_tdata,  // chan, sample, pad
    input  logic                              s_axis_tlast,  // block_end
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [39:0]                       m_axis_tdata,  // out_chan, average,
                                                             // millivolts, resistance, pad
    output logic                              m_axis_tuser   // fresh
);

    awfca_pkg::t_cfg r_cfg;
    awfca_pkg::t_job w_push_job;
    awfca_pkg::t_job w_head_job;

    logic                              w_push;
    logic                              w_pop;
    logic                              w_full;
    logic                              w_empty;
    logic [awfca_pkg::CHAN_W-1:0]      w_out_chan;
    logic [awfca_pkg::SMP_W-1:0]       w_out_avg;
    logic [awfca_pkg::SMP_W-1:0]       w_out_mv;
    logic [awfca_pkg::SMP_W-1:0]       w_out_ohm;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.filter_mask <= awfca_pkg::RST_FILTER_MASK;
            r_cfg.limit_low   <= awfca_pkg::RST_LIMIT_LOW;
            r_cfg.limit_high  <= awfca_pkg::RST_LIMIT_HIGH;
            r_cfg.vref_mv     <= awfca_pkg::RST_VREF_MV;
            r_cfg.ohm_offset  <= awfca_pkg::RST_OHM_OFFSET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                awfca_pkg::REG_FILTER_MASK: r_cfg.filter_mask <= i_cfg_wdata[awfca_pkg::MASK_W-1:0];
                awfca_pkg::REG_LIMIT_LOW:   r_cfg.limit_low   <= i_cfg_wdata;
                awfca_pkg::REG_LIMIT_HIGH:  r_cfg.limit_high  <= i_cfg_wdata;
                awfca_pkg::REG_VREF_MV:     r_cfg.vref_mv     <= i_cfg_wdata;
                awfca_pkg::REG_OHM_OFFSET:  r_cfg.ohm_offset  <= i_cfg_wdata[awfca_pkg::OHM_W-1:0];
                default: begin
                end
            endcase
        end
    end

    awfca_front #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_valid  (s_axis_tvalid),
        .o_ready  (s_axis_tready),
        .i_chan   (s_axis_tdata[2:0]),
        .i_sample (s_axis_tdata[14:3]),
        .i_last   (s_axis_tlast),
        .i_q_full (w_full),
        .o_push   (w_push),
        .o_job    (w_push_job)
    );

    awfca_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_push_job),
        .i_pop   (w_pop),
        .o_job   (w_head_job),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    awfca_back #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_q_empty    (w_empty),
        .i_job        (w_head_job),
        .o_pop        (w_pop),
        .o_valid      (m_axis_tvalid),
        .i_ready      (m_axis_tready),
        .o_chan       (w_out_chan),
        .o_average    (w_out_avg),
        .o_millivolts (w_out_mv),
        .o_resistance (w_out_ohm),
        .o_fresh      (m_axis_tuser)
    );

    assign m_axis_tdata = {1'b0, w_out_ohm, w_out_mv, w_out_avg, w_out_chan};

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_full)
        else $error("job pushed into full queue");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_empty)
        else $error("job popped from empty queue");

    a_push_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |=> !w_empty)
        else $error("queued job lost");

endmodule
